// ===== rtl/fbpa_pkg.sv =====
// shared constants, status codes and controller/datapath interface types for the pool allocator
package fbpa_pkg;

    localparam int MAX_CHUNKS_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int ADDR_W    = 48;
    localparam int ITEM_W    = 17;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    localparam int ITEM_MAX_VAL = 65536;
    localparam int COUNT_RESET  = 1024;

    localparam logic [ITEM_W-1:0] ITEM_MAX   = ITEM_W'(ITEM_MAX_VAL);
    localparam logic [ITEM_W-1:0] ITEM_MIN   = ITEM_W'(1);
    localparam logic [ITEM_W-1:0] ITEM_RESET = ITEM_W'(64);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(2);

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED    = 3'd0,
        ST_EXHAUSTED  = 3'd1,
        ST_RELEASED   = 3'd2,
        ST_OUTSIDE    = 3'd3,
        ST_MISALIGNED = 3'd4,
        ST_NONE_OUT   = 3'd5
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load_item;
        logic    alloc_take;
        logic    grant_mul;
        logic    end_mul;
        logic    end_add;
        logic    div_start;
        logic    push;
        logic    res_load;
        status_t res_status;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic stack_nonempty;
        logic fresh_avail;
        logic outside;
        logic in_header;
        logic none_out;
        logic div_done;
        logic rem_zero;
    } stat_t;

endpackage

// ===== rtl/fbpa_div.sv =====
// iterative restoring divider, one quotient bit per cycle, for the chunk index and remainder
module fbpa_div import fbpa_pkg::*; #(
    parameter int QUO_W = 10,
    parameter int DEN_W = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [QUO_W+DEN_W-1:0] dividend,
    input  logic [DEN_W-1:0]       divisor,
    output logic                   done,
    output logic [QUO_W-1:0]       quotient,
    output logic                   rem_zero
);

    localparam int REM_W  = QUO_W + DEN_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              ge;

    assign ge = (rem_reg >= den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= dividend;
            den_reg  <= REM_W'(divisor) << (QUO_W - 1);
            quo_reg  <= '0;
            step_reg <= STEP_W'(QUO_W - 1);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - den_reg;
            end
            quo_reg  <= QUO_W'({quo_reg, ge});
            den_reg  <= den_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/fbpa_dp.sv =====
// datapath: configuration, free stack memory, counters, shared multiplier and result register
module fbpa_dp import fbpa_pkg::*; #(
    parameter int MAX_CHUNKS   = MAX_CHUNKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic [ADDR_W-1:0]    in_address,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output status_t              res_status,
    output logic [ADDR_W-1:0]    res_grant,
    output logic [COUNT_W-1:0]   res_free,
    output logic [COUNT_W-1:0]   res_used
);

    localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
    localparam int IDX_W      = $clog2(MAX_CHUNKS);
    localparam int STRIDE_W   = $clog2(ITEM_MAX_VAL + HEADER_BYTES + 1);
    localparam int PROD_W     = CNT_W + STRIDE_W;
    localparam int REM_W      = IDX_W + STRIDE_W;
    localparam int END_W      = ADDR_W + 1;
    localparam int COUNT_INIT = (MAX_CHUNKS < COUNT_RESET) ? MAX_CHUNKS : COUNT_RESET;

    localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_CHUNKS);
    localparam logic [ADDR_W-1:0] HDR     = ADDR_W'(HEADER_BYTES);

    logic [ADDR_W-1:0]   base_reg;
    logic [ITEM_W-1:0]   item_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    top_reg;
    logic [CNT_W-1:0]    fresh_reg;
    logic [CNT_W-1:0]    out_reg;

    logic [ADDR_W-1:0]   addr_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                from_stack_reg;
    logic [IDX_W-1:0]    mem_q_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [END_W-1:0]    end_reg;
    logic [ADDR_W-1:0]   off_reg;

    status_t             res_status_reg;
    logic [ADDR_W-1:0]   res_grant_reg;
    logic [COUNT_W-1:0]  res_free_reg;
    logic [COUNT_W-1:0]  res_used_reg;

    logic [IDX_W-1:0]    mem [MAX_CHUNKS];

    logic [ITEM_W-1:0]   cfg_item;
    logic [ITEM_W-1:0]   item_clamped;
    logic [COUNT_W-1:0]  cfg_cnt;
    logic [CNT_W-1:0]    count_clamped;
    logic [STRIDE_W-1:0] stride;
    logic [CNT_W-1:0]    top_dec;
    logic [CNT_W-1:0]    mul_a;
    logic [CNT_W:0]      free_sum;
    logic                div_done;
    logic                div_rem_zero;
    logic [IDX_W-1:0]    div_quo;
    logic                can_push;

    always_comb begin
        cfg_item = cfg_data[ITEM_W-1:0];
        if (cfg_item == '0) begin
            item_clamped = ITEM_MIN;
        end else if (cfg_item > ITEM_MAX) begin
            item_clamped = ITEM_MAX;
        end else begin
            item_clamped = cfg_item;
        end
        cfg_cnt = cfg_data[COUNT_W-1:0];
        if (32'(cfg_cnt) > 32'(MAX_CHUNKS)) begin
            count_clamped = MAX_CNT;
        end else begin
            count_clamped = CNT_W'(cfg_cnt);
        end
    end

    assign stride   = STRIDE_W'(item_reg) + STRIDE_W'(HEADER_BYTES);
    assign top_dec  = top_reg - CNT_W'(1);
    assign can_push = (top_reg < MAX_CNT);

    // configuration and counters; a chunk count write rebuilds the pool
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            item_reg  <= ITEM_RESET;
            count_reg <= CNT_W'(COUNT_INIT);
            top_reg   <= '0;
            fresh_reg <= '0;
            out_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BASE: begin
                        base_reg <= cfg_data;
                    end
                    CFG_ITEM: begin
                        item_reg <= item_clamped;
                    end
                    CFG_COUNT: begin
                        count_reg <= count_clamped;
                        top_reg   <= '0;
                        fresh_reg <= '0;
                        out_reg   <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            if (cmd.alloc_take) begin
                if (top_reg != '0) begin
                    top_reg <= top_dec;
                end else begin
                    fresh_reg <= fresh_reg + CNT_W'(1);
                end
                out_reg <= out_reg + CNT_W'(1);
            end
            if (cmd.push) begin
                if (can_push) begin
                    top_reg <= top_reg + CNT_W'(1);
                end
                out_reg <= out_reg - CNT_W'(1);
            end
        end
    end

    // free stack, registered read
    always_ff @(posedge aclk) begin
        if (cmd.push && can_push) begin
            mem[top_reg[IDX_W-1:0]] <= div_quo;
        end
        if (cmd.alloc_take && (top_reg != '0)) begin
            mem_q_reg <= mem[top_dec[IDX_W-1:0]];
        end
    end

    assign mul_a = cmd.grant_mul ?
                   (from_stack_reg ? CNT_W'(mem_q_reg) : CNT_W'(idx_reg)) : count_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            addr_reg <= in_address;
        end
        if (cmd.alloc_take) begin
            from_stack_reg <= (top_reg != '0);
            idx_reg        <= fresh_reg[IDX_W-1:0];
        end
        if (cmd.grant_mul || cmd.end_mul) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(stride);
        end
        if (cmd.end_add) begin
            end_reg <= END_W'(base_reg) + END_W'(prod_reg);
            off_reg <= addr_reg - base_reg;
        end
    end

    fbpa_div #(
        .QUO_W (IDX_W),
        .DEN_W (STRIDE_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (REM_W'(off_reg - HDR)),
        .divisor  (stride),
        .done     (div_done),
        .quotient (div_quo),
        .rem_zero (div_rem_zero)
    );

    always_comb begin
        stat.stack_nonempty = (top_reg != '0);
        stat.fresh_avail    = (fresh_reg < count_reg);
        stat.outside        = (addr_reg < base_reg) || (END_W'(addr_reg) >= end_reg);
        stat.in_header      = (off_reg < HDR);
        stat.none_out       = (out_reg == '0);
        stat.div_done       = div_done;
        stat.rem_zero       = div_rem_zero;
    end

    assign free_sum = {1'b0, top_reg} +
                      ((count_reg > fresh_reg) ? {1'b0, count_reg - fresh_reg} : '0);

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_grant_reg  <= (cmd.res_status == ST_GRANTED) ?
                              (base_reg + HDR + ADDR_W'(prod_reg)) : '0;
            res_free_reg   <= COUNT_W'(free_sum);
            res_used_reg   <= COUNT_W'(out_reg);
        end
    end

    assign res_status = res_status_reg;
    assign res_grant  = res_grant_reg;
    assign res_free   = res_free_reg;
    assign res_used   = res_used_reg;

`ifndef SYNTHESIS
    a_count_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CNT_W+1)'(out_reg) + (CNT_W+1)'(top_reg)) == (CNT_W+1)'(fresh_reg))
        else $error("outstanding plus stacked chunks differ from chunks handed out fresh");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> can_push)
        else $error("push onto a full free stack");
    a_take_avail: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_take |-> ((top_reg != '0) || (fresh_reg < count_reg)))
        else $error("allocation taken from an empty pool");
`endif

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// controller state machine: sequences allocate and release words and the result handshake
module fbpa_ctrl import fbpa_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    input  logic  in_func,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_SEL,
        S_A_WAIT,
        S_A_MUL,
        S_R_MUL,
        S_R_END,
        S_R_CHK,
        S_R_DIV,
        S_R_DEC,
        S_RESULT
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t status_reg;
    status_t status_next;
    logic    out_valid_reg;
    logic    slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb begin
        state_next     = state_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.res_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = (in_func == FUNC_RELEASE) ? S_R_MUL : S_A_SEL;
                end
            end
            S_A_SEL: begin
                if (stat.stack_nonempty || stat.fresh_avail) begin
                    cmd.alloc_take = 1'b1;
                    state_next     = S_A_WAIT;
                end else begin
                    status_next = ST_EXHAUSTED;
                    state_next  = S_RESULT;
                end
            end
            S_A_WAIT: begin
                state_next = S_A_MUL;
            end
            S_A_MUL: begin
                cmd.grant_mul = 1'b1;
                status_next   = ST_GRANTED;
                state_next    = S_RESULT;
            end
            S_R_MUL: begin
                cmd.end_mul = 1'b1;
                state_next  = S_R_END;
            end
            S_R_END: begin
                cmd.end_add = 1'b1;
                state_next  = S_R_CHK;
            end
            S_R_CHK: begin
                if (stat.outside) begin
                    status_next = ST_OUTSIDE;
                    state_next  = S_RESULT;
                end else if (stat.in_header) begin
                    status_next = ST_MISALIGNED;
                    state_next  = S_RESULT;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = S_R_DIV;
                end
            end
            S_R_DIV: begin
                if (stat.div_done) begin
                    state_next = S_R_DEC;
                end
            end
            S_R_DEC: begin
                if (!stat.rem_zero) begin
                    status_next = ST_MISALIGNED;
                end else if (stat.none_out) begin
                    status_next = ST_NONE_OUT;
                end else begin
                    cmd.push    = 1'b1;
                    status_next = ST_RELEASED;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (slot_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            status_reg    <= ST_GRANTED;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            if (cmd.res_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_load_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> slot_free)
        else $error("result register overwritten before it was taken");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted while one is in progress");
    a_push_checked: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (stat.rem_zero && !stat.none_out))
        else $error("chunk pushed without a clean boundary or with none outstanding");
`endif

endmodule

// ===== rtl/fixed_block_pool_allocator_unit.sv =====
// top level of the fixed-size block pool allocator
// usage
//   input channel s_*: one word per request. s_tuser carries func (allocate or
//   release), s_tdata carries the address to release (ignored for allocate).
//   result channel m_*: exactly one word per request. m_tuser carries the
//   status code, m_tdata the granted address and the free and used counts.
//   config port: cfg_we with cfg_index 0 base address, 1 item size, 2 chunk
//   count; write only while idle. a chunk count write empties the pool state.
// sequencing
//   one request at a time. allocate ends granted or exhausted; release ends early
//   when rejected on range or header, otherwise it runs the restoring divider,
//   one index bit per cycle.
//   the next word is taken once the previous result is in the output register
// reset
//   aresetn low clears counts and config to defaults; the free stack memory
//   is not cleared, only entries pushed since are ever read
// stall
//   a stalled receiver holds the result in the output register; the block
//   still takes the next word and parks its result until the slot frees
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
    parameter int MAX_CHUNKS   = MAX_CHUNKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,   // [47:0] address
    input  logic [0:0]           s_tuser,   // [0] func

    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,   // [47:0] grant_address, [58:48] free_chunks,
                                            // [69:59] used_chunks, [71:70] zero
    output logic [2:0]           m_tuser    // [2:0] status
);

    cmd_t                cmd;
    stat_t               stat;
    status_t             res_status;
    logic [ADDR_W-1:0]   res_grant;
    logic [COUNT_W-1:0]  res_free;
    logic [COUNT_W-1:0]  res_used;

    // sequencing: request acceptance, allocate and release flows, result handshake
    fbpa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_func   (s_tuser[0]),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // config registers, free stack, counters, arithmetic and result register
    fbpa_dp #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_address (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (res_status),
        .res_grant  (res_grant),
        .res_free   (res_free),
        .res_used   (res_used)
    );

    // pack result word, highest field first
    assign m_tdata = {2'b00, res_used, res_free, res_grant};
    assign m_tuser = res_status;

endmodule
